### rtl/core/bchl_pkg.sv
// bchl_pkg: types and constants for the bounded cursor history list
// no dependencies
package bchl_pkg;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned ENTRY_BITS = 64;
  localparam int unsigned SLOT_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned LIM_W      = 6;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(20);

  typedef enum logic [3:0] {
    KIND_APPEND = 4'd0,
    KIND_INSERT = 4'd1,
    KIND_DELETE = 4'd2,
    KIND_NEXT   = 4'd3,
    KIND_PREV   = 4'd4,
    KIND_FIRST  = 4'd5,
    KIND_LAST   = 4'd6,
    KIND_READ   = 4'd7,
    KIND_CLEAR  = 4'd8
  } kind_e;

  typedef struct packed {
    logic [3:0]            kind;
    logic [ENTRY_BITS-1:0] payload;
  } item_t;

  typedef struct packed {
    logic                  ok;
    logic [ENTRY_BITS-1:0] entry_out;
    logic                  cursor_valid;
    logic [CNT_W-1:0]      entries;
    logic                  evicted;
  } res_t;

endpackage

### rtl/core/bchl_core.sv
// bchl_core: list state (slots, links, pointers) and the single-pass command logic
// depends on bchl_pkg
module bchl_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  bchl_pkg::item_t            item_i,
  input  logic [bchl_pkg::LIM_W-1:0] limit_i,
  output bchl_pkg::res_t             res_o
);
  import bchl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [ENTRY_BITS-1:0] store_q [DEPTH];
  logic [SLOT_W-1:0]     nxt_q [DEPTH];
  logic [SLOT_W-1:0]     prv_q [DEPTH];
  logic [SLOT_W-1:0]     nxt_d [DEPTH];
  logic [SLOT_W-1:0]     prv_d [DEPTH];
  logic [DEPTH-1:0]      use_q, use_d;
  logic [SLOT_W-1:0]     head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;
  logic [SLOT_W-1:0]     free_slot;
  logic [LIM_W-1:0]      lim;
  logic                  ok, ev;

  always_comb begin
    free_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!use_q[i]) free_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    if (limit_i == '0) lim = LIM_W'(1);
    else if (limit_i > LIM_W'(DEPTH)) lim = LIM_W'(DEPTH);
    else lim = limit_i;
  end

  always_comb begin
    logic              after_c, at_front, nonempty, hp, hn;
    logic [SLOT_W-1:0] s, h, nx, pv, c;
    nxt_d   = nxt_q;
    prv_d   = prv_q;
    use_d   = use_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_slot = free_slot;
    ok      = 1'b0;
    ev      = 1'b0;
    after_c = 1'b0;
    at_front = 1'b0;
    s = free_slot; h = head_q; nx = '0; pv = '0; c = cur_q;
    hp = 1'b0; hn = 1'b0;
    nonempty = (cnt_q != '0);
    if (vld_i) begin
      unique case (item_i.kind)
        KIND_APPEND, KIND_INSERT: begin
          ok      = 1'b1;
          wr_en   = 1'b1;
          after_c = (item_i.kind == KIND_INSERT) && nonempty;
          if (!nonempty) begin
            use_d[s] = 1'b1;
            head_d = s; tail_d = s; cur_d = s;
            cnt_d  = CNT_W'(1);
          end else begin
            if (cnt_q >= DEPTH_C) begin
              h = head_q;
              at_front = after_c && (cur_q == h);
              head_d = nxt_d[h];
              use_d[h] = 1'b0;
              cnt_d = cnt_d - CNT_W'(1);
              if (cur_d == h) cur_d = head_d;
              ev = 1'b1;
              s  = h;
            end
            wr_slot = s;
            use_d[s] = 1'b1;
            if (at_front) begin
              nxt_d[s] = head_d;
              prv_d[head_d] = s;
              head_d = s;
            end else if (!after_c || cur_d == tail_d) begin
              prv_d[s] = tail_d;
              nxt_d[tail_d] = s;
              tail_d = s;
            end else begin
              nx = nxt_d[cur_d];
              prv_d[s] = cur_d;
              nxt_d[s] = nx;
              nxt_d[cur_d] = s;
              prv_d[nx] = s;
            end
            cur_d = s;
            cnt_d = cnt_d + CNT_W'(1);
            if (!ev && cnt_d > CNT_W'(lim)) begin
              h = head_d;
              head_d = nxt_d[h];
              use_d[h] = 1'b0;
              cnt_d = cnt_d - CNT_W'(1);
              if (cur_d == h) cur_d = head_d;
              ev = 1'b1;
            end
          end
        end
        KIND_DELETE: begin
          if (nonempty) begin
            ok = 1'b1;
            c  = cur_q;
            hp = (c != head_q);
            hn = (c != tail_q);
            pv = prv_q[c];
            nx = nxt_q[c];
            if (hp) nxt_d[pv] = nx; else head_d = nx;
            if (hn) begin
              prv_d[nx] = pv;
              cur_d = nx;
            end else begin
              tail_d = pv;
              cur_d  = pv;
            end
            use_d[c] = 1'b0;
            cnt_d = cnt_q - CNT_W'(1);
            if (cnt_d == '0) begin
              head_d = '0; tail_d = '0; cur_d = '0;
            end
          end
        end
        KIND_NEXT: begin
          if (nonempty && cur_q != tail_q) begin
            cur_d = nxt_q[cur_q];
            ok = 1'b1;
          end
        end
        KIND_PREV: begin
          if (nonempty && cur_q != head_q) begin
            cur_d = prv_q[cur_q];
            ok = 1'b1;
          end
        end
        KIND_FIRST: begin
          if (nonempty) begin
            cur_d = head_q;
            ok = 1'b1;
          end
        end
        KIND_LAST: begin
          if (nonempty) begin
            cur_d = tail_q;
            ok = 1'b1;
          end
        end
        KIND_READ: ok = nonempty;
        KIND_CLEAR: begin
          use_d = '0;
          head_d = '0; tail_d = '0; cur_d = '0;
          cnt_d = '0;
          ok = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_o.ok           = ok;
    res_o.evicted      = ev;
    res_o.entries      = cnt_d;
    res_o.cursor_valid = (cnt_d != '0);
    if (cnt_d == '0) res_o.entry_out = '0;
    else if (wr_en && cur_d == wr_slot) res_o.entry_out = item_i.payload;
    else res_o.entry_out = store_q[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      cur_q  <= '0;
      cnt_q  <= '0;
    end else begin
      use_q  <= use_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cur_q  <= cur_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
    prv_q <= prv_d;
    if (wr_en) store_q[wr_slot] <= item_i.payload;
  end

endmodule

### rtl/core/bounded_cursor_history_list.sv
// bounded_cursor_history_list: top level, item register, limit register, result register
// depends on bchl_pkg and bchl_core
//
//  channel  | direction | handshake              | payload
//  command  | in        | start_i, busy_o        | cmd_i (item_t)
//  result   | out       | done_o strobe          | res_o (res_t)
//  config   | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (history limit)
//
// an item is taken every cycle; it is held in the item register, then its result in the result register with done_o
// the list logic does one command per cycle in bchl_core between the two registers
// reset empties the list and loads a history limit of 20
// busy_o stays low and the receiver cannot stall
module bounded_cursor_history_list (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  bchl_pkg::item_t            cmd_i,
  output logic                       done_o,
  output bchl_pkg::res_t             res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bchl_pkg::LIM_W-1:0] cfg_data_i
);
  import bchl_pkg::*;

  logic             vld_q;
  item_t            item_q;
  logic [LIM_W-1:0] limit_q;
  res_t             res_d, res_q;
  logic             done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  bchl_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld_q),
    .item_i  (item_q),
    .limit_i (limit_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      done_q  <= 1'b0;
      limit_q <= LIMIT_RESET;
    end else begin
      vld_q  <= start_i && !busy_o;
      done_q <= vld_q;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= cmd_i;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o) else $error("item without result");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.entries <= 6'd32) else $error("entry count above depth");
  a_cursor_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.cursor_valid == (res_o.entries != '0)) else $error("cursor mismatch");
  a_evict_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.evicted |-> ($past(item_q.kind) == KIND_APPEND ||
      $past(item_q.kind) == KIND_INSERT)) else $error("eviction without add");

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for bounded_cursor_history_list
// drives list commands and limit writes, predicts each result with a local list model
// depends on bchl_pkg and the rtl of bounded_cursor_history_list
`timescale 1ns / 100ps

module tb_top;
  import bchl_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  item_t cmd_i;
  logic done_o;
  res_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [LIM_W-1:0] cfg_data_i;

  bounded_cursor_history_list DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .done_o(done_o), .res_o(res_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // list model
  logic [63:0] m_data [DEPTH];
  logic [4:0] m_next [DEPTH];
  logic [4:0] m_prev [DEPTH];
  bit m_used [DEPTH];
  logic [4:0] m_head, m_tail, m_cur;
  int m_count;
  int m_limit;

  res_t pending_q[$];
  int mismatches;
  int taken;

  typedef struct {
    logic [3:0] kind;
    logic [63:0] payload;
    bit has_exp;
    res_t exp_res;
  } row_t;

  function automatic res_t mk(bit ok, logic [63:0] e, bit cv, int n, bit ev);
    res_t r;
    r.ok = ok; r.entry_out = e; r.cursor_valid = cv; r.entries = n[5:0]; r.evicted = ev;
    return r;
  endfunction

  function automatic logic [4:0] first_free();
    for (int i = 0; i < DEPTH; i++) if (!m_used[i]) return i[4:0];
    return '0;
  endfunction

  function automatic void unlink_head();
    logic [4:0] o;
    o = m_head;
    m_head = m_next[o];
    m_used[o] = 0;
    m_count--;
    if (m_cur == o) m_cur = m_head;
  endfunction

  function automatic bit add_entry(bit after, logic [63:0] d);
    bit ev;
    bit front;
    logic [4:0] s, h, nx;
    int lim;
    ev = 0; front = 0;
    lim = (m_limit == 0) ? 1 : (m_limit > DEPTH ? DEPTH : m_limit);
    if (m_count == 0) begin
      s = first_free();
      m_data[s] = d; m_used[s] = 1;
      m_head = s; m_tail = s; m_cur = s; m_count = 1;
      return 0;
    end
    if (m_count >= DEPTH) begin
      h = m_head;
      if (after && m_cur == h) front = 1;
      unlink_head();
      ev = 1;
      s = h;
    end else begin
      s = first_free();
    end
    m_data[s] = d; m_used[s] = 1;
    if (front) begin
      m_next[s] = m_head; m_prev[m_head] = s; m_head = s;
    end else if (!after || m_cur == m_tail) begin
      m_prev[s] = m_tail; m_next[m_tail] = s; m_tail = s;
    end else begin
      nx = m_next[m_cur];
      m_prev[s] = m_cur; m_next[s] = nx; m_next[m_cur] = s; m_prev[nx] = s;
    end
    m_cur = s;
    m_count++;
    if (!ev && m_count > lim) begin
      unlink_head();
      ev = 1;
    end
    return ev;
  endfunction

  function automatic void remove_at_cursor();
    logic [4:0] c, pv, nx;
    bit hp, hn;
    c = m_cur;
    hp = (c != m_head); hn = (c != m_tail);
    pv = m_prev[c]; nx = m_next[c];
    if (hp) m_next[pv] = nx; else m_head = nx;
    if (hn) begin
      m_prev[nx] = pv; m_cur = nx;
    end else begin
      m_tail = pv; m_cur = pv;
    end
    m_used[c] = 0;
    m_count--;
    if (m_count == 0) begin
      m_head = '0; m_tail = '0; m_cur = '0;
    end
  endfunction

  function automatic res_t list_step(logic [3:0] k, logic [63:0] d);
    bit ok, ev, ne;
    ok = 0; ev = 0; ne = (m_count != 0);
    case (k)
      KIND_APPEND: begin
        ev = add_entry(0, d); ok = 1;
      end
      KIND_INSERT: begin
        ev = add_entry(ne, d); ok = 1;
      end
      KIND_DELETE: if (ne) begin
        remove_at_cursor(); ok = 1;
      end
      KIND_NEXT: if (ne && m_cur != m_tail) begin
        m_cur = m_next[m_cur]; ok = 1;
      end
      KIND_PREV: if (ne && m_cur != m_head) begin
        m_cur = m_prev[m_cur]; ok = 1;
      end
      KIND_FIRST: if (ne) begin
        m_cur = m_head; ok = 1;
      end
      KIND_LAST: if (ne) begin
        m_cur = m_tail; ok = 1;
      end
      KIND_READ: ok = ne;
      KIND_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) m_used[i] = 0;
        m_head = '0; m_tail = '0; m_cur = '0; m_count = 0; ok = 1;
      end
      default: ;
    endcase
    ne = (m_count != 0);
    return mk(ok, ne ? m_data[m_cur] : 64'd0, ne, m_count, ev);
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        res_t e;
        e = pending_q.pop_front();
        if (res_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, res_o);
        end
      end
    end
  end

  task automatic send_item(logic [3:0] k, logic [63:0] d, bit has_exp, res_t given);
    res_t p;
    int w;
    w = $urandom_range(0, 6);
    if (w != 0) begin
      start_i <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= '{kind: k, payload: d};
    do @(posedge clk_i); while (busy_o);
    p = list_step(k, d);
    if (has_exp && p !== given) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", given, p);
    end
    pending_q.push_back(has_exp ? given : p);
    taken++;
    @(negedge clk_i);
  endtask

  task automatic write_limit(int v);
    int guard;
    guard = 0;
    start_i <= 1'b0;
    while (pending_q.size() != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[LIM_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    m_limit = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  row_t rows[$];
  int lims[] = '{1, 32, 0, 63, 2, 5, 33, 20};

  initial begin
    logic [3:0] k;
    int guard;
    start_i = 0; cmd_i = '0; cfg_valid_i = 0; cfg_data_i = '0;
    mismatches = 0; taken = 0;
    for (int i = 0; i < DEPTH; i++) begin
      m_used[i] = 0; m_data[i] = '0; m_next[i] = '0; m_prev[i] = '0;
    end
    m_head = '0; m_tail = '0; m_cur = '0; m_count = 0; m_limit = LIMIT_RESET;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // empty-list cases, extremes, unknown kinds
    rows.push_back('{KIND_READ, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_DELETE, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_NEXT, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_PREV, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_FIRST, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_LAST, 64'd0, 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{KIND_INSERT, '1, 1, mk(1, '1, 1, 1, 0)});
    rows.push_back('{KIND_APPEND, 64'd0, 1, mk(1, 0, 1, 2, 0)});
    rows.push_back('{4'd15, 64'd5, 1, mk(0, 0, 1, 2, 0)});
    rows.push_back('{4'd9, 64'd5, 0, '0});
    rows.push_back('{KIND_PREV, 64'd0, 1, mk(1, '1, 1, 2, 0)});
    rows.push_back('{KIND_PREV, 64'd0, 1, mk(0, '1, 1, 2, 0)});
    rows.push_back('{KIND_INSERT, 64'h5555_aaaa_5555_aaaa, 0, '0});
    rows.push_back('{KIND_NEXT, 64'd0, 0, '0});
    rows.push_back('{KIND_LAST, 64'd0, 0, '0});
    rows.push_back('{KIND_NEXT, 64'd0, 0, '0});
    rows.push_back('{KIND_FIRST, 64'd0, 0, '0});
    rows.push_back('{KIND_DELETE, 64'd0, 0, '0});
    rows.push_back('{KIND_LAST, 64'd0, 0, '0});
    rows.push_back('{KIND_DELETE, 64'd0, 0, '0});
    rows.push_back('{KIND_CLEAR, 64'd0, 1, mk(1, 0, 0, 0, 0)});
    foreach (rows[i]) send_item(rows[i].kind, rows[i].payload, rows[i].has_exp, rows[i].exp_res);

    // random phases over several limits, weighted towards adds to hit eviction and full pool
    foreach (lims[p]) begin
      write_limit(lims[p]);
      for (int n = 0; n < 250; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: k = KIND_APPEND;
          5, 6, 7, 8: k = KIND_INSERT;
          9, 10: k = KIND_DELETE;
          11, 12: k = KIND_NEXT;
          13, 14: k = KIND_PREV;
          15: k = KIND_FIRST;
          16: k = KIND_LAST;
          17: k = KIND_READ;
          18: k = ($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_READ;
          default: k = 4'($urandom_range(0, 15));
        endcase
        send_item(k, rand_word(), 0, '0);
      end
    end

    start_i <= 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
